@@ rtl/scsa_pkg.sv @@
`default_nettype none

package scsa_pkg;

  // busy flags are kept in words of this many slots
  localparam int unsigned WORD_BITS = 32;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // pool codes
  localparam logic [1:0] POOL_SMALL   = 2'd0;
  localparam logic [1:0] POOL_MEDIUM  = 2'd1;
  localparam logic [1:0] POOL_LARGE   = 2'd2;
  // pool code that names no pool, a free of it is ignored
  localparam logic [1:0] POOL_INVALID = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SMALL_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_MEDIUM_LIMIT = 2'd1;
  localparam logic [1:0] CFG_LARGE_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_ENTRIES      = 2'd3;

  // configuration reset values
  localparam logic [11:0] SMALL_LIMIT_RST  = 12'h058;
  localparam logic [11:0] MEDIUM_LIMIT_RST = 12'h080;
  localparam logic [11:0] LARGE_LIMIT_RST  = 12'h200;
  localparam logic [8:0]  ENTRIES_RST      = 9'd200;

  typedef struct packed {
    logic        mode;
    logic [11:0] request_size;
    logic [1:0]  free_pool;
    logic [7:0]  free_slot;
    logic        held_for_resend;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] granted_pool;
    logic [7:0] granted_slot;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/size_class_slot_allocator.sv @@
`default_nettype none

// channel   | ports                                   | direction | handshake
// ----------+-----------------------------------------+-----------+-------------------------
// request   | start, busy, req_i                      | in        | start high, busy low
// result    | done_o, rsp_o                           | out       | one-cycle strobe
// config    | cfg_we_i, cfg_addr_i, cfg_wdata_i       | in        | write enable, no wait
//
// busy flags live in one word-wide ram (32 slots per word), one row per pool word;
// the next-fit scan reads one word per cycle and finds the first free slot in it.
// allocate: the request is taken in idle, then each pool is tried in S_POOL and, when
// the size is admitted, scanned word by word in S_SCAN (up to ceil(n/32)+1 words); a
// free reads its word and clears the bit in S_FREE_WR, a refused or ignored free reports
// from idle. the result strobe is registered from the last state of the request.
// a row valid flag per ram word makes all slots free right after reset, no sweep.
// results cannot be held off; a new request is taken in the cycle the result shows.

module size_class_slot_allocator #(
  parameter int unsigned POOL_DEPTH = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire scsa_pkg::req_t   req_i,
  output logic                  done_o,
  output scsa_pkg::rsp_t        rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_addr_i,
  input  wire logic [11:0]      cfg_wdata_i
);

  localparam int unsigned WB   = scsa_pkg::WORD_BITS;
  localparam int unsigned BW   = $clog2(WB);
  localparam int unsigned IW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned WPP  = (POOL_DEPTH + WB - 1) / WB;
  localparam int unsigned WW   = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int unsigned CW   = (WW + BW + 1 > 10) ? WW + BW + 1 : 10;
  localparam int unsigned ROWS = 3 * (1 << WW);
  localparam int unsigned AW   = $clog2(ROWS);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_POOL    = 4'b0010,
    S_SCAN    = 4'b0100,
    S_FREE_WR = 4'b1000
  } state_e;

  // lowest set bit of a word
  function automatic logic [BW:0] first_set(input logic [WB-1:0] v);
    logic [BW:0] r;
    r = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, BW'(i)};
      end
    end
    return r;
  endfunction

  state_e          state_q, state_d;
  scsa_pkg::req_t  req_q, req_d;
  logic [1:0]      pool_q, pool_d;
  logic [WW-1:0]   w_q, w_d;
  logic            wrapped_q, wrapped_d;
  logic [IW-1:0]   start_p_q, start_p_d;
  logic [WW-1:0]   start_w_q, start_w_d;
  logic [IW-1:0]   ptr_q [3];
  logic [IW-1:0]   ptr_d [3];
  logic [11:0]     lim_q [3];
  logic [8:0]      eiu_q;
  logic            done_q, done_d;
  scsa_pkg::rsp_t  rsp_q, rsp_d;
  logic [ROWS-1:0] vld_q;
  logic            rd_vld_q;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [WB-1:0]   ram_wdata, ram_rdata;

  logic [CW-1:0]   n_c, nm1_c, eiu_ext, sp_ext, fslot_ext, start_ext;
  logic [WW-1:0]   last_w_c, next_w_c;
  logic [IW-1:0]   ptr_sel, sp_c;
  logic [11:0]     lim_sel;
  logic            admit_c, final_c, free_ok_c;
  logic [WB-1:0]   word_c, mask_c, cand_c;
  logic [BW:0]     hit_c;
  logic [CW-1:0]   hit_pos;
  logic [CW-1:0]   pos_b;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // active entry count, clamped to one and to the pool depth
  always_comb begin
    eiu_ext = CW'(eiu_q);
    if (eiu_q == '0) begin
      n_c = CW'(1);
    end else if (eiu_ext > CW'(POOL_DEPTH)) begin
      n_c = CW'(POOL_DEPTH);
    end else begin
      n_c = eiu_ext;
    end
    nm1_c    = n_c - CW'(1);
    last_w_c = nm1_c[WW+BW-1:BW];
  end

  // pool selection of pointer and limit
  always_comb begin
    case (pool_q)
      scsa_pkg::POOL_SMALL: begin
        ptr_sel = ptr_q[0];
        lim_sel = lim_q[0];
      end
      scsa_pkg::POOL_MEDIUM: begin
        ptr_sel = ptr_q[1];
        lim_sel = lim_q[1];
      end
      scsa_pkg::POOL_LARGE: begin
        ptr_sel = ptr_q[2];
        lim_sel = lim_q[2];
      end
      default: begin
        ptr_sel = '0;
        lim_sel = '0;
      end
    endcase
    admit_c = (req_q.request_size <= lim_sel);
    sp_c    = (CW'(ptr_sel) >= n_c) ? '0 : ptr_sel;
    sp_ext  = CW'(sp_c);
  end

  // word scan: mask slots outside the lap, pick the first free one
  always_comb begin
    word_c    = rd_vld_q ? ram_rdata : '0;
    start_ext = CW'(start_p_q);
    for (int b = 0; b < WB; b++) begin
      pos_b     = CW'({w_q, BW'(b)});
      mask_c[b] = (pos_b < n_c) && (wrapped_q || (pos_b >= start_ext));
    end
    cand_c   = ~word_c & mask_c;
    hit_c    = first_set(cand_c);
    hit_pos  = CW'({w_q, hit_c[BW-1:0]});
    final_c  = wrapped_q && (w_q == start_w_q);
    next_w_c = (w_q == last_w_c) ? '0 : w_q + WW'(1);
    pos_b    = '0;
  end

  assign fslot_ext = CW'(req_i.free_slot);
  assign free_ok_c = (req_i.free_pool != scsa_pkg::POOL_INVALID) &&
                     (fslot_ext < CW'(POOL_DEPTH));

  // sequencer
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    pool_d    = pool_q;
    w_d       = w_q;
    wrapped_d = wrapped_q;
    start_p_d = start_p_q;
    start_w_d = start_w_q;
    ptr_d     = ptr_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.mode == scsa_pkg::MODE_FREE) begin
            if (req_i.held_for_resend) begin
              done_d = 1'b1;
              rsp_d  = '{status: scsa_pkg::ST_REFUSED, granted_pool: '0, granted_slot: '0};
            end else if (!free_ok_c) begin
              done_d = 1'b1;
              rsp_d  = '{status: scsa_pkg::ST_DONE, granted_pool: '0, granted_slot: '0};
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'({req_i.free_pool, fslot_ext[WW+BW-1:BW]});
              state_d   = S_FREE_WR;
            end
          end else begin
            pool_d  = scsa_pkg::POOL_SMALL;
            state_d = S_POOL;
          end
        end
      end
      S_POOL: begin
        if (admit_c) begin
          start_p_d = sp_c;
          start_w_d = sp_ext[WW+BW-1:BW];
          w_d       = sp_ext[WW+BW-1:BW];
          wrapped_d = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = AW'({pool_q, sp_ext[WW+BW-1:BW]});
          state_d   = S_SCAN;
        end else if (pool_q == scsa_pkg::POOL_LARGE) begin
          done_d  = 1'b1;
          rsp_d   = '{status: scsa_pkg::ST_NONE, granted_pool: '0, granted_slot: '0};
          state_d = S_IDLE;
        end else begin
          pool_d = pool_q + 2'd1;
        end
      end
      S_SCAN: begin
        if (hit_c[BW]) begin
          ram_we    = 1'b1;
          ram_waddr = AW'({pool_q, w_q});
          ram_wdata = word_c | (WB'(1) << hit_c[BW-1:0]);
          for (int i = 0; i < 3; i++) begin
            if (pool_q == 2'(i)) begin
              ptr_d[i] = hit_pos[IW-1:0];
            end
          end
          done_d  = 1'b1;
          rsp_d   = '{status: scsa_pkg::ST_DONE, granted_pool: pool_q,
                      granted_slot: hit_pos[7:0]};
          state_d = S_IDLE;
        end else if (final_c) begin
          for (int i = 0; i < 3; i++) begin
            if (pool_q == 2'(i)) begin
              ptr_d[i] = start_p_q;
            end
          end
          if (pool_q == scsa_pkg::POOL_LARGE) begin
            done_d  = 1'b1;
            rsp_d   = '{status: scsa_pkg::ST_NONE, granted_pool: '0, granted_slot: '0};
            state_d = S_IDLE;
          end else begin
            pool_d  = pool_q + 2'd1;
            state_d = S_POOL;
          end
        end else begin
          w_d       = next_w_c;
          wrapped_d = wrapped_q || (w_q == last_w_c);
          ram_re    = 1'b1;
          ram_raddr = AW'({pool_q, next_w_c});
        end
      end
      S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'({req_q.free_pool, WW'(CW'(req_q.free_slot) >> BW)});
        ram_wdata = word_c & ~(WB'(1) << req_q.free_slot[BW-1:0]);
        done_d    = 1'b1;
        rsp_d     = '{status: scsa_pkg::ST_DONE, granted_pool: '0, granted_slot: '0};
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      pool_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        ptr_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      pool_q  <= pool_d;
      ptr_q   <= ptr_d;
    end
  end

  // request payload and scan position
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rsp_q     <= rsp_d;
    w_q       <= w_d;
    wrapped_q <= wrapped_d;
    start_p_q <= start_p_d;
    start_w_q <= start_w_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q[0] <= scsa_pkg::SMALL_LIMIT_RST;
      lim_q[1] <= scsa_pkg::MEDIUM_LIMIT_RST;
      lim_q[2] <= scsa_pkg::LARGE_LIMIT_RST;
      eiu_q    <= scsa_pkg::ENTRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        scsa_pkg::CFG_SMALL_LIMIT:  lim_q[0] <= cfg_wdata_i;
        scsa_pkg::CFG_MEDIUM_LIMIT: lim_q[1] <= cfg_wdata_i;
        scsa_pkg::CFG_LARGE_LIMIT:  lim_q[2] <= cfg_wdata_i;
        scsa_pkg::CFG_ENTRIES:      eiu_q    <= cfg_wdata_i[8:0];
        default: begin
        end
      endcase
    end
  end

  // row valid flags: an unwritten word reads as all slots free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
      end
    end
  end

  scsa_ram #(
    .WIDTH (WB),
    .DEPTH (ROWS)
  ) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // an accepted request either reports at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request neither busy nor reported");

  // the busy ram is only written while finishing a request
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SCAN || state_q == S_FREE_WR))
    else $error("busy ram written outside a finishing state");

  // the scan never runs on the unused pool code
  a_scan_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_POOL) |-> (pool_q != scsa_pkg::POOL_INVALID))
    else $error("scan on an invalid pool");

  // a result whose status is not done carries no grant
  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != scsa_pkg::ST_DONE) |->
      (rsp_o.granted_pool == '0 && rsp_o.granted_slot == '0))
    else $error("grant reported with a failure status");

endmodule

`default_nettype wire

@@ rtl/scsa_ram.sv @@
`default_nettype none

module scsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ dv/size_class_slot_allocator_tb.sv @@
`timescale 1ns / 100ps

module size_class_slot_allocator_tb;
  import scsa_pkg::*;

  localparam int unsigned POOL_DEPTH   = 256;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned IDLE_SETTLE  = 2;
  localparam int unsigned END_SETTLE   = 40;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 120;

  localparam logic [1:0] POOL_CODE [3] = '{POOL_SMALL, POOL_MEDIUM, POOL_LARGE};

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    req_t        req;
    bit          pinned;
    rsp_t        want;
    logic [1:0]  reg_idx;
    logic [11:0] reg_val;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        request_q = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = CFG_SMALL_LIMIT;
  logic [11:0] cfg_wdata_i = '0;

  // typed-in outcome travelling with the request
  bit          pin_q = 1'b0;
  rsp_t        pin_want_q = '0;

  // mirror of the allocator
  logic [11:0] size_cap [3];
  logic [8:0]  slots_used;
  bit          slot_taken [3][POOL_DEPTH];
  logic [7:0]  scan_ptr [3];

  rsp_t        awaited_outcomes [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned alloc_share = 55;

  size_class_slot_allocator #(
    .POOL_DEPTH(POOL_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (request_q),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned active_slots();
    if (slots_used == 0) return 1;
    if (slots_used > POOL_DEPTH) return POOL_DEPTH;
    return slots_used;
  endfunction

  // next-fit grant over the pools that admit the size, or the effect of a free
  function automatic rsp_t next_fit_outcome(req_t r);
    rsp_t        res;
    int unsigned n;
    int unsigned p;
    int unsigned lap;
    int          pool;
    bit          found;
    res = '{status: ST_DONE, granted_pool: POOL_SMALL, granted_slot: 8'd0};
    found = 1'b0;
    n = active_slots();
    if (r.mode == MODE_ALLOC) begin
      for (pool = 0; pool < 3; pool++) begin
        if (!found && r.request_size <= size_cap[pool]) begin
          p = (scan_ptr[pool] >= n) ? 0 : scan_ptr[pool];
          for (lap = 0; lap < n && !found; lap++) begin
            if (!slot_taken[pool][p]) begin
              found = 1'b1;
              slot_taken[pool][p] = 1'b1;
              res.granted_pool = POOL_CODE[pool];
              res.granted_slot = 8'(p);
            end else begin
              p = (p + 1 >= n) ? 0 : p + 1;
            end
          end
          scan_ptr[pool] = 8'(p);
        end
      end
      if (!found) res.status = ST_NONE;
    end else if (r.held_for_resend) begin
      res.status = ST_REFUSED;
    end else if (r.free_pool != POOL_INVALID) begin
      slot_taken[r.free_pool][r.free_slot] = 1'b0;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // score results, track register writes, predict each accepted request
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t predicted;
    if (!rst_ni) begin
      size_cap[0] = SMALL_LIMIT_RST;
      size_cap[1] = MEDIUM_LIMIT_RST;
      size_cap[2] = LARGE_LIMIT_RST;
      slots_used = ENTRIES_RST;
      foreach (slot_taken[p, s]) slot_taken[p][s] = 1'b0;
      foreach (scan_ptr[p]) scan_ptr[p] = '0;
      awaited_outcomes.delete();
    end else begin
      if (done_o) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result with nothing outstanding: status %0d pool %0d slot %0d",
                 rsp_o.status, rsp_o.granted_pool, rsp_o.granted_slot);
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("status", 8'(want.status), 8'(rsp_o.status));
          check_field("granted_pool", 8'(want.granted_pool), 8'(rsp_o.granted_pool));
          check_field("granted_slot", want.granted_slot, rsp_o.granted_slot);
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_SMALL_LIMIT:  size_cap[0] = cfg_wdata_i;
          CFG_MEDIUM_LIMIT: size_cap[1] = cfg_wdata_i;
          CFG_LARGE_LIMIT:  size_cap[2] = cfg_wdata_i;
          CFG_ENTRIES:      slots_used = cfg_wdata_i[8:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        predicted = next_fit_outcome(request_q);
        awaited_outcomes.push_back(pin_q ? pin_want_q : predicted);
      end
    end
  end

  // watchdog on cycles without any accepted request, result or write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // directed table builders
  function automatic void add_alloc(logic [11:0] size, bit pin, logic [1:0] st,
                                    logic [1:0] pool, logic [7:0] slot);
    stim_row_t row;
    row = '{kind: ROW_REQ, req: '0, pinned: pin, want: '0, reg_idx: '0, reg_val: '0};
    row.req = '{mode: MODE_ALLOC, request_size: size, free_pool: POOL_INVALID,
                free_slot: 8'hff, held_for_resend: 1'b1};
    row.want = '{status: st, granted_pool: pool, granted_slot: slot};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_free(logic [1:0] pool, logic [7:0] slot, bit held,
                                   bit pin, logic [1:0] st);
    stim_row_t row;
    row = '{kind: ROW_REQ, req: '0, pinned: pin, want: '0, reg_idx: '0, reg_val: '0};
    row.req = '{mode: MODE_FREE, request_size: 12'hfff, free_pool: pool,
                free_slot: slot, held_for_resend: held};
    row.want = '{status: st, granted_pool: POOL_SMALL, granted_slot: 8'd0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg(logic [1:0] idx, logic [11:0] val);
    stim_row_t row;
    row = '{kind: ROW_REG, req: '0, pinned: 1'b0, want: '0, reg_idx: idx, reg_val: val};
    directed_rows.push_back(row);
  endfunction

  // random request, sizes gathered around the limits, frees mostly in range
  function automatic req_t random_request();
    req_t        r;
    int unsigned n;
    int unsigned k;
    n = active_slots();
    r.mode = ($urandom_range(0, 99) < alloc_share) ? MODE_ALLOC : MODE_FREE;
    case ($urandom_range(0, 7))
      0, 1:    r.request_size = 12'($urandom_range(0, 4095));
      2, 3, 4: begin
        k = $urandom_range(0, 2);
        r.request_size = size_cap[k] + 12'($urandom_range(0, 2)) - 12'd1;
      end
      5:       r.request_size = 12'($urandom_range(0, 15));
      6:       r.request_size = 12'hfff;
      default: r.request_size = 12'($urandom_range(0, 255));
    endcase
    r.free_pool = ($urandom_range(0, 11) == 0) ? POOL_INVALID
                                                : POOL_CODE[$urandom_range(0, 2)];
    r.free_slot = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, n - 1));
    r.held_for_resend = ($urandom_range(0, 7) == 0);
    return r;
  endfunction

  function automatic logic [11:0] random_cap();
    return ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 600))
                                        : 12'($urandom_range(0, 4095));
  endfunction

  // hold off new requests until every outcome is back
  task automatic settle_to_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (awaited_outcomes.size() != 0 || busy) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    settle_to_idle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic program_regs(logic [11:0] s, logic [11:0] m, logic [11:0] l,
                              logic [8:0] e);
    write_reg(CFG_SMALL_LIMIT, s);
    write_reg(CFG_MEDIUM_LIMIT, m);
    write_reg(CFG_LARGE_LIMIT, l);
    write_reg(CFG_ENTRIES, 12'(e));
  endtask

  // present one request and return at the edge that takes it
  task automatic issue(req_t r, bit pin, rsp_t want);
    start      <= 1'b1;
    request_q  <= r;
    pin_q      <= pin;
    pin_want_q <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned burst_left;
    bit          no_idle;

    // reset defaults: small 88, medium 128, large 512, 200 slots
    add_alloc(12'd0,    1, ST_DONE, POOL_SMALL, 8'd0);
    add_alloc(12'd88,   1, ST_DONE, POOL_SMALL, 8'd1);
    add_alloc(12'd89,   1, ST_DONE, POOL_MEDIUM, 8'd0);
    add_alloc(12'd129,  1, ST_DONE, POOL_LARGE, 8'd0);
    add_alloc(12'd513,  1, ST_NONE, POOL_SMALL, 8'd0);
    add_alloc(12'hfff,  1, ST_NONE, POOL_SMALL, 8'd0);
    add_free(POOL_SMALL, 8'd0, 1, 1, ST_REFUSED);
    add_free(POOL_SMALL, 8'd0, 0, 1, ST_DONE);
    add_free(POOL_INVALID, 8'hff, 0, 1, ST_DONE);
    // already free and past the slots in use
    add_free(POOL_LARGE, 8'hff, 0, 1, ST_DONE);
    add_alloc(12'd0, 0, ST_DONE, POOL_SMALL, 8'd0);
    add_alloc(12'd0, 0, ST_DONE, POOL_SMALL, 8'd0);
    // zero slots act as one, pointers past the wrap restart at slot zero
    add_reg(CFG_ENTRIES, 12'd0);
    add_alloc(12'd0, 0, ST_DONE, POOL_SMALL, 8'd0);
    add_alloc(12'd0, 1, ST_NONE, POOL_SMALL, 8'd0);
    add_free(POOL_MEDIUM, 8'd0, 0, 1, ST_DONE);
    add_alloc(12'd100, 0, ST_DONE, POOL_SMALL, 8'd0);
    // oversize slot count clips to the pool depth
    add_reg(CFG_ENTRIES, 12'd511);
    add_reg(CFG_SMALL_LIMIT, 12'hfff);
    add_alloc(12'hfff, 0, ST_DONE, POOL_SMALL, 8'd0);
    add_free(POOL_SMALL, 8'hff, 1, 1, ST_REFUSED);
    // all limits at zero
    add_reg(CFG_SMALL_LIMIT, 12'd0);
    add_reg(CFG_MEDIUM_LIMIT, 12'd0);
    add_reg(CFG_LARGE_LIMIT, 12'd0);
    add_alloc(12'd0, 0, ST_DONE, POOL_SMALL, 8'd0);
    add_alloc(12'd1, 1, ST_NONE, POOL_SMALL, 8'd0);
    // two slots per pool, spill into medium and large, then all full
    add_reg(CFG_ENTRIES, 12'd2);
    add_reg(CFG_SMALL_LIMIT, 12'hfff);
    add_reg(CFG_MEDIUM_LIMIT, 12'hfff);
    add_reg(CFG_LARGE_LIMIT, 12'hfff);
    add_alloc(12'd7, 0, ST_DONE, POOL_SMALL, 8'd0);
    add_alloc(12'd2048, 0, ST_DONE, POOL_SMALL, 8'd0);
    add_alloc(12'hfff, 1, ST_NONE, POOL_SMALL, 8'd0);
    add_free(POOL_LARGE, 8'd1, 0, 1, ST_DONE);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        issue(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].want);
        pause_sender($urandom_range(0, 3));
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_regs(SMALL_LIMIT_RST, MEDIUM_LIMIT_RST, LARGE_LIMIT_RST, ENTRIES_RST);
        1: program_regs(random_cap(), random_cap(), random_cap(), 9'd0);
        2: program_regs(random_cap(), random_cap(), random_cap(), 9'd1);
        3: program_regs(12'hfff, 12'hfff, 12'hfff, 9'd511);
        4: program_regs(12'd0, 12'd0, 12'd0, 9'd8);
        5: program_regs(random_cap(), random_cap(), random_cap(), 9'd256);
        default: program_regs(random_cap(), random_cap(), random_cap(),
                              9'($urandom_range(2, 48)));
      endcase
      alloc_share = $urandom_range(40, 70);
      no_idle = (phase == 6);
      burst_left = $urandom_range(1, 24);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // let the outstanding requests drain halfway through even phases
        if (k == PHASE_ITEMS / 2 && phase % 2 == 0) settle_to_idle();
        issue(random_request(), 1'b0, '0);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (!no_idle) pause_sender($urandom_range(1, 12));
        end
      end
    end

    settle_to_idle();
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/scsa_pkg.sv
rtl/scsa_ram.sv
rtl/size_class_slot_allocator.sv
dv/size_class_slot_allocator_tb.sv
